FILE: hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operation codes, word width, sequencer states and datapath control struct.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int EXP_BITS  = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);
    localparam int IN_BITS   = 4 * WORD_BITS + EXP_BITS;
    localparam int OUT_BITS  = 2 * WORD_BITS;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_POW  = 4'd4,
        OP_EQ   = 4'd5,
        OP_NE   = 4'd6,
        OP_LT   = 4'd7,
        OP_GT   = 4'd8,
        OP_LE   = 4'd9,
        OP_GE   = 4'd10,
        OP_SIMP = 4'd11
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_X1,      // an*bd  (or an*bn for mul)
        ST_X2,      // ad*bn
        ST_X3,      // ad*bd
        ST_CMB,     // combine cross products
        ST_PMUL,    // pow: acc *= base where bit set
        ST_PSQ,     // pow: base *= base
        ST_PNEXT,   // pow: switch to second part
        ST_SNORM,   // simplify: sign fixup
        ST_GDIV,    // gcd: x % y, one bit per cycle
        ST_GSTEP,   // gcd: rotate
        ST_QDIV,    // divide magnitude by gcd
        ST_QFIN,
        ST_DONE
    } state_t;

    // control from sequencer to the shared multiplier
    typedef struct packed {
        logic  go;
        word_t a;
        word_t b;
    } mul_req_t;

endpackage

FILE: hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: rational add/sub/mul/div/pow/compare/simplify
// Sequence from input transfer to m_axis_tvalid: add/sub/mul/div, compares and
// undefined codes pass X1, X2, X3, CMB; pow loops PMUL/PSQ once per bit of the
// exponent magnitude (at most 32 bits), for numerator and denominator parts;
// simplify runs one divider pass per Euclid step, then two quotient divisions;
// a gcd of zero goes from GSTEP straight to DONE. One item at a time:
// s_axis_tready is high only while idle, so it rises together with
// m_axis_tvalid; a finished result waits in DONE while the output is full.
// Reset (aresetn low, synchronous) returns the sequencer to idle, no result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] a_num, [63:32] a_den, [95:64] b_num, [127:96] b_den,
    // [159:128] exponent
    input  logic [rau_pkg::IN_BITS-1:0]    s_axis_tdata,
    input  logic [3:0]                     s_axis_tuser,   // operation
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] res_num, [63:32] res_den
    output logic [rau_pkg::OUT_BITS-1:0]   m_axis_tdata,
    // [0] compare_true, [1] zero_gcd
    output logic [1:0]                     m_axis_tuser
);
    localparam int W  = rau_pkg::WORD_BITS;
    localparam int XB = 4 * rau_pkg::WORD_BITS;   // exponent field offset
    typedef logic [rau_pkg::EXP_BITS-1:0] exp_t;

    rau_pkg::state_t state_reg, state_next;
    rau_pkg::op_t    op_reg;
    rau_pkg::word_t  an_reg, ad_reg, bn_reg, bd_reg;
    exp_t            e_reg, e_next;      // remaining exponent bits
    exp_t            em_reg;             // exponent magnitude
    exp_t            exp_in;
    logic            neg_reg;            // exponent was negative
    rau_pkg::word_t  acc_reg, base_reg, lhs_reg, rhs_reg;
    rau_pkg::word_t  base_eff;            // base, or fresh square from the multiplier
    rau_pkg::word_t  rn_reg, rd_reg;      // result staging / pow part 1
    rau_pkg::word_t  gx_reg, gy_reg;      // gcd operands
    rau_pkg::word_t  sn_reg, sd_reg;      // sign-fixed pair
    logic            part_reg;            // pow: second fraction part
    logic            qsel_reg;            // simplify: quotient for den
    logic            sq_pend_reg;         // pow: square still in the multiplier
    logic            cmp_reg, zg_reg;
    logic            out_valid_reg;
    logic [rau_pkg::OUT_BITS-1:0] out_data_reg;
    logic [1:0]      out_user_reg;

    rau_pkg::mul_req_t mreq;
    rau_pkg::word_t    prod;
    logic              dv_start, dv_done;
    rau_pkg::word_t    dv_a, dv_b, dv_q, dv_r;
    logic              accept;
    logic              done_fire;

    rau_mul u_mul (.aclk(aclk), .req(mreq), .prod(prod));

    rau_divu u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .dividend(dv_a), .divisor(dv_b),
        .done(dv_done), .quot(dv_q), .rem(dv_r)
    );

    function automatic rau_pkg::word_t wabs(rau_pkg::word_t x);
        return x[W-1] ? rau_pkg::word_t'(-x) : x;
    endfunction

    function automatic logic slt(rau_pkg::word_t x, rau_pkg::word_t y);
        return $signed(x) < $signed(y);
    endfunction

    assign s_axis_tready = (state_reg == rau_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    assign accept    = s_axis_tvalid && s_axis_tready;
    // result register free now or emptied by this edge's output transfer
    assign done_fire = (state_reg == rau_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready);
    assign exp_in    = s_axis_tdata[XB +: rau_pkg::EXP_BITS];
    // the square issued in PSQ lands in prod during the following PMUL
    assign base_eff  = sq_pend_reg ? prod : base_reg;

    // next-state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (accept) begin
                    priority if (s_axis_tuser == rau_pkg::OP_POW)
                        state_next = rau_pkg::ST_PMUL;
                    else if (s_axis_tuser == rau_pkg::OP_SIMP)
                        state_next = rau_pkg::ST_SNORM;
                    else
                        state_next = rau_pkg::ST_X1;
                end
            end
            rau_pkg::ST_X1:  state_next = rau_pkg::ST_X2;
            rau_pkg::ST_X2:  state_next = rau_pkg::ST_X3;
            rau_pkg::ST_X3:  state_next = rau_pkg::ST_CMB;
            rau_pkg::ST_CMB: state_next = rau_pkg::ST_DONE;
            rau_pkg::ST_PMUL: begin
                if (e_reg == '0) state_next = part_reg ? rau_pkg::ST_DONE
                                                       : rau_pkg::ST_PNEXT;
                else state_next = rau_pkg::ST_PSQ;
            end
            rau_pkg::ST_PSQ:   state_next = rau_pkg::ST_PMUL;
            rau_pkg::ST_PNEXT: state_next = rau_pkg::ST_PMUL;
            rau_pkg::ST_SNORM: state_next = rau_pkg::ST_GSTEP;
            rau_pkg::ST_GSTEP: begin
                if (gy_reg == '0) state_next = (gx_reg == '0) ? rau_pkg::ST_DONE
                                                              : rau_pkg::ST_QDIV;
                else state_next = rau_pkg::ST_GDIV;
            end
            rau_pkg::ST_GDIV: if (dv_done) state_next = rau_pkg::ST_GSTEP;
            rau_pkg::ST_QDIV: state_next = rau_pkg::ST_QFIN;
            rau_pkg::ST_QFIN: begin
                if (dv_done) state_next = qsel_reg ? rau_pkg::ST_DONE
                                                   : rau_pkg::ST_QDIV;
            end
            rau_pkg::ST_DONE: state_next = done_fire ? rau_pkg::ST_IDLE : rau_pkg::ST_DONE;
            default:          state_next = rau_pkg::ST_IDLE;
        endcase
    end

    // shared unit requests
    always_comb begin
        mreq     = '{go: 1'b0, a: '0, b: '0};
        dv_start = 1'b0;
        dv_a     = '0;
        dv_b     = gx_reg;
        e_next   = e_reg;
        unique case (state_reg)
            rau_pkg::ST_X1: begin
                mreq.go = 1'b1;
                mreq.a  = an_reg;
                mreq.b  = (op_reg == rau_pkg::OP_MUL) ? bn_reg : bd_reg;
            end
            rau_pkg::ST_X2: begin
                mreq.go = 1'b1; mreq.a = ad_reg; mreq.b = bn_reg;
            end
            rau_pkg::ST_X3: begin
                mreq.go = 1'b1; mreq.a = ad_reg; mreq.b = bd_reg;
            end
            rau_pkg::ST_PMUL: begin
                mreq.go = (e_reg != '0); mreq.a = acc_reg;
                mreq.b  = e_reg[0] ? base_eff : rau_pkg::word_t'(1);
            end
            rau_pkg::ST_PSQ: begin
                mreq.go = 1'b1; mreq.a = base_reg; mreq.b = base_reg;
                e_next  = e_reg >> 1;
            end
            rau_pkg::ST_GSTEP: begin
                dv_start = (gy_reg != '0);
                dv_a     = gx_reg;
                dv_b     = gy_reg;
            end
            rau_pkg::ST_QDIV: begin
                dv_start = 1'b1;
                dv_a     = wabs(qsel_reg ? sd_reg : sn_reg);
                dv_b     = gx_reg;
            end
            default: ;
        endcase
    end

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rau_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= done_fire || (out_valid_reg && !m_axis_tready);
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (accept) begin
                    op_reg  <= rau_pkg::op_t'(s_axis_tuser);
                    an_reg  <= s_axis_tdata[W-1:0];
                    ad_reg  <= s_axis_tdata[2*W-1:W];
                    bn_reg  <= s_axis_tdata[3*W-1:2*W];
                    bd_reg  <= s_axis_tdata[4*W-1:3*W];
                    rn_reg  <= '0;
                    rd_reg  <= '0;
                    cmp_reg <= 1'b0;
                    zg_reg  <= 1'b0;
                    part_reg <= 1'b0;
                    qsel_reg <= 1'b0;
                    sq_pend_reg <= 1'b0;
                    acc_reg <= rau_pkg::word_t'(1);
                    neg_reg <= exp_in[rau_pkg::EXP_BITS-1];
                    if (exp_in[rau_pkg::EXP_BITS-1]) begin
                        em_reg   <= exp_t'(-exp_in);
                        e_reg    <= exp_t'(-exp_in);
                        base_reg <= s_axis_tdata[2*W-1:W];
                    end else begin
                        em_reg   <= exp_in;
                        e_reg    <= exp_in;
                        base_reg <= s_axis_tdata[W-1:0];
                    end
                end
            end
            rau_pkg::ST_X2: lhs_reg <= prod;
            rau_pkg::ST_X3: rhs_reg <= prod;
            rau_pkg::ST_CMB: begin
                unique case (op_reg)
                    rau_pkg::OP_ADD: begin rn_reg <= lhs_reg + rhs_reg; rd_reg <= prod; end
                    rau_pkg::OP_SUB: begin rn_reg <= lhs_reg - rhs_reg; rd_reg <= prod; end
                    rau_pkg::OP_MUL: begin rn_reg <= lhs_reg; rd_reg <= prod; end
                    rau_pkg::OP_DIV: begin rn_reg <= lhs_reg; rd_reg <= rhs_reg; end
                    rau_pkg::OP_EQ:  cmp_reg <= lhs_reg == rhs_reg;
                    rau_pkg::OP_NE:  cmp_reg <= lhs_reg != rhs_reg;
                    rau_pkg::OP_LT:  cmp_reg <= slt(lhs_reg, rhs_reg);
                    rau_pkg::OP_GT:  cmp_reg <= slt(rhs_reg, lhs_reg);
                    rau_pkg::OP_LE:  cmp_reg <= !slt(rhs_reg, lhs_reg);
                    rau_pkg::OP_GE:  cmp_reg <= !slt(lhs_reg, rhs_reg);
                    default: ;
                endcase
            end
            rau_pkg::ST_PMUL: begin
                base_reg    <= base_eff;
                sq_pend_reg <= 1'b0;
                if (e_reg == '0) begin
                    if (part_reg) rd_reg <= acc_reg;
                    else          rn_reg <= acc_reg;
                end
            end
            rau_pkg::ST_PSQ: begin
                acc_reg     <= prod;    // product issued in PMUL
                e_reg       <= e_next;
                sq_pend_reg <= 1'b1;
            end
            rau_pkg::ST_PNEXT: begin
                part_reg    <= 1'b1;
                acc_reg     <= rau_pkg::word_t'(1);
                e_reg       <= em_reg;
                base_reg    <= neg_reg ? an_reg : ad_reg;
                sq_pend_reg <= 1'b0;
            end
            rau_pkg::ST_SNORM: begin
                if (ad_reg[W-1]) begin
                    sn_reg <= rau_pkg::word_t'(-an_reg);
                    sd_reg <= rau_pkg::word_t'(-ad_reg);
                    gx_reg <= wabs(rau_pkg::word_t'(-an_reg));
                    gy_reg <= wabs(rau_pkg::word_t'(-ad_reg));
                end else begin
                    sn_reg <= an_reg;
                    sd_reg <= ad_reg;
                    gx_reg <= wabs(an_reg);
                    gy_reg <= wabs(ad_reg);
                end
            end
            rau_pkg::ST_GSTEP: begin
                if (gy_reg == '0 && gx_reg == '0) begin
                    rn_reg <= an_reg;
                    rd_reg <= ad_reg;
                    zg_reg <= 1'b1;
                end
            end
            rau_pkg::ST_GDIV: begin
                if (dv_done) begin
                    gx_reg <= gy_reg;
                    gy_reg <= dv_r;
                end
            end
            rau_pkg::ST_QFIN: begin
                if (dv_done) begin
                    if (qsel_reg)
                        rd_reg <= sd_reg[W-1] ? rau_pkg::word_t'(-dv_q) : dv_q;
                    else
                        rn_reg <= sn_reg[W-1] ? rau_pkg::word_t'(-dv_q) : dv_q;
                    qsel_reg <= 1'b1;
                end
            end
            rau_pkg::ST_DONE: begin
                if (done_fire) begin
                    out_data_reg <= {rd_reg, rn_reg};
                    out_user_reg <= {zg_reg, cmp_reg};
                end
            end
            default: ;
        endcase
    end

    // Assertions
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> state_reg == rau_pkg::ST_IDLE)
        else $error("ready outside idle");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rau_pkg::ST_DONE |=> m_axis_tvalid)
        else $error("result lost");
    a_cmp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata == '0)
        else $error("compare result with nonzero fraction");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while waiting");
endmodule

FILE: hdl/rau_mul.sv
// ----------------------------------------------------------------------------
// rau_mul: shared wrapping word multiplier
// One registered product per request, modulo 2^WORD_BITS.
// ----------------------------------------------------------------------------
module rau_mul (
    input  logic               aclk,
    input  rau_pkg::mul_req_t  req,
    output rau_pkg::word_t     prod
);
    rau_pkg::word_t prod_reg;

    always_ff @(posedge aclk) begin
        if (req.go) begin
            prod_reg <= rau_pkg::word_t'(req.a * req.b);
        end
    end

    assign prod = prod_reg;
endmodule

FILE: hdl/rau_divu.sv
// ----------------------------------------------------------------------------
// rau_divu: restoring unsigned divider, one quotient bit per cycle
// Gives quotient and remainder once all WORD_BITS quotient bits are done.
// ----------------------------------------------------------------------------
module rau_divu (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  rau_pkg::word_t dividend,
    input  rau_pkg::word_t divisor,
    output logic           done,
    output rau_pkg::word_t quot,
    output rau_pkg::word_t rem
);
    localparam int W = rau_pkg::WORD_BITS;

    rau_pkg::word_t q_reg, r_reg, d_reg;
    logic [rau_pkg::CNT_BITS-1:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [W:0] trial;

    assign trial = {r_reg, q_reg[W-1]} - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= rau_pkg::CNT_BITS'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - rau_pkg::CNT_BITS'(1);
                if (cnt_reg == rau_pkg::CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                r_reg <= trial[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b1};
            end else begin
                r_reg <= {r_reg[W-2:0], q_reg[W-1]};
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;
endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the rational arithmetic unit
// Drives operation items over the input stream, predicts each result in a
// scoreboard class and compares it field by field with what comes back.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic        cmp;
        logic        zg;
    } rat_result_t;

    // scoreboard: predicts results and holds the queue of pending ones
    class rat_scoreboard;
        rat_result_t pending[$];
        int          errors;

        function logic [31:0] pow_word(logic [31:0] base, logic [31:0] e);
            logic [31:0] acc;
            acc = 32'd1;
            while (e != 0) begin
                if (e[0]) acc = acc * base;
                e = e >> 1;
                base = base * base;
            end
            return acc;
        endfunction

        function logic [31:0] gcd_word(logic [31:0] x, logic [31:0] y);
            logic [31:0] t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        function logic [31:0] abs_word(logic [31:0] x);
            return x[31] ? -x : x;
        endfunction

        function logic [31:0] div_mag(logic [31:0] x, logic [31:0] g);
            logic [31:0] q;
            q = abs_word(x) / g;
            return x[31] ? -q : q;
        endfunction

        function void note_transfer(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                                    logic [31:0] bn, logic [31:0] bd, logic [31:0] ex);
            rat_result_t r;
            logic [31:0] lhs, rhs, n, d, g;
            r = '0;
            lhs = an * bd;
            rhs = ad * bn;
            case (op)
                rau_pkg::OP_ADD: begin r.num = lhs + rhs; r.den = ad * bd; end
                rau_pkg::OP_SUB: begin r.num = lhs - rhs; r.den = ad * bd; end
                rau_pkg::OP_MUL: begin r.num = an * bn; r.den = ad * bd; end
                rau_pkg::OP_DIV: begin r.num = lhs; r.den = rhs; end
                rau_pkg::OP_POW: begin
                    if (ex[31]) begin
                        r.num = pow_word(ad, -ex);
                        r.den = pow_word(an, -ex);
                    end else begin
                        r.num = pow_word(an, ex);
                        r.den = pow_word(ad, ex);
                    end
                end
                rau_pkg::OP_EQ: r.cmp = (lhs == rhs);
                rau_pkg::OP_NE: r.cmp = (lhs != rhs);
                rau_pkg::OP_LT: r.cmp = ($signed(lhs) < $signed(rhs));
                rau_pkg::OP_GT: r.cmp = ($signed(rhs) < $signed(lhs));
                rau_pkg::OP_LE: r.cmp = !($signed(rhs) < $signed(lhs));
                rau_pkg::OP_GE: r.cmp = !($signed(lhs) < $signed(rhs));
                rau_pkg::OP_SIMP: begin
                    n = an;
                    d = ad;
                    if (ad[31]) begin n = -an; d = -ad; end
                    g = gcd_word(abs_word(n), abs_word(d));
                    if (g == 0) begin
                        r.num = an; r.den = ad; r.zg = 1'b1;
                    end else begin
                        r.num = div_mag(n, g); r.den = div_mag(d, g);
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [63:0] data, logic [1:0] user);
            rat_result_t e;
            if (pending.size() == 0) begin
                report("unexpected result", '0, data);
                return;
            end
            e = pending.pop_front();
            if (data[31:0] !== e.num)   report("res_num", 64'(e.num), 64'(data[31:0]));
            if (data[63:32] !== e.den)  report("res_den", 64'(e.den), 64'(data[63:32]));
            if (user[0] !== e.cmp)      report("compare_true", 64'(e.cmp), 64'(user[0]));
            if (user[1] !== e.zg)       report("zero_gcd", 64'(e.zg), 64'(user[1]));
        endfunction

        function void report(string what, logic [63:0] exp_v, logic [63:0] got);
            $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got, $realtime);
            errors++;
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic [3:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    rational_arithmetic_unit DUT (.*);

    rat_scoreboard sb;
    int send_idle_pct;     // chance per cycle that the sender holds off
    int recv_stall_pct;    // chance per cycle that the receiver stalls
    longint cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle counter and watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 20_000_000) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver side: random stall, check each transfer
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // drive one item and wait for its transfer
    task automatic send_item(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd, logic [31:0] ex);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {ex, bd, bn, ad, an};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_transfer(op, an, ad, bn, bd, ex);
    endtask

    // operand with a mix of extremes, small values and full random words
    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(2) - 1;
            1: return $urandom_range(20) - 10;
            2: return $urandom_range(200) - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_exp();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return $urandom_range(40) - 20;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        sb = new();
        sb.errors = 0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every operation, extremes, special cases
        for (int op = rau_pkg::OP_ADD; op <= rau_pkg::OP_SIMP; op++)
            send_item(4'(op), 32'd3, 32'd4, -32'sd5, 32'd6, 32'd3);
        send_item(rau_pkg::OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                  32'h7fff_ffff, 0);
        send_item(rau_pkg::OP_POW, 32'd3, -32'sd2, 0, 0, -32'sd5);
        send_item(rau_pkg::OP_POW, 32'd1, 32'hffff_ffff, 0, 0, 32'h8000_0000);
        send_item(rau_pkg::OP_POW, 32'd7, 32'd5, 0, 0, 32'h7fff_ffff);
        send_item(rau_pkg::OP_POW, 32'd7, 32'd5, 0, 0, 0);
        send_item(rau_pkg::OP_SIMP, 0, 0, 0, 0, 0);                       // gcd zero
        send_item(rau_pkg::OP_SIMP, 32'd6, 32'h8000_0000, 0, 0, 0);       // most negative den
        send_item(rau_pkg::OP_SIMP, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        send_item(rau_pkg::OP_SIMP, -32'sd12, -32'sd18, 0, 0, 0);
        send_item(rau_pkg::OP_SIMP, 0, -32'sd7, 0, 0, 0);
        send_item(rau_pkg::OP_LT, 32'h8000_0000, 1, 32'h7fff_ffff, 1, 0);
        send_item(rau_pkg::OP_EQ, 1, 2, 2, 4, 0);
        send_item(4'd12, 1, 2, 3, 4, 5);
        send_item(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff);

        // random part in idle/stall phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 27 : 68) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 27 : 68) : 0;
            for (int i = 0; i < 320; i++)
                send_item(4'($urandom_range(99) < 4 ? $urandom_range(15, 12)
                                                    : $urandom_range(rau_pkg::OP_SIMP)),
                          rand_word(), rand_word(), rand_word(), rand_word(), rand_exp());
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
